// ===== hw/rtl/epi_ec_pkg.sv =====
// Shared widths, register indexes and defaults for the EPI edge-confidence block.
// Used by the top level and by its port checker; depends on nothing else.
package epi_ec_pkg;

    localparam int PIX_W        = 8;
    localparam int SQ_W         = 2 * PIX_W;
    localparam int SQ_MAX       = 65025;
    localparam int CONF_W       = 20;
    localparam int COL_W        = 10;
    localparam int HALF_W       = 3;
    localparam int OUT_TDATA_W  = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 20;

    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_HALF    = 7;

    localparam logic [CONF_W-1:0] THRESHOLD_RST   = CONF_W'(1300);
    localparam logic [HALF_W-1:0] HALF_WINDOW_RST = HALF_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = CFG_IDX_W'(1);

endpackage

// ===== hw/rtl/epi_edge_confidence.sv =====
// Edge-confidence stage for one row of an epipolar image, one gray pixel per transfer.
// Depends on epi_ec_pkg for widths, register indexes and defaults.
// A new pixel is taken only in the idle state, after every result that it releases has
// been loaded for output; each result sums a window of at most 2h+1 terms through the one
// squarer (read, square, accumulate); a result waiting at the output stalls the sequencer.
// Reset clears the sequencer, counters and output register; the pixel ring is not reset.
module epi_edge_confidence #(
    parameter int MAX_COLUMNS = epi_ec_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_HALF    = epi_ec_pkg::DEF_MAX_HALF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Pixel stream. tdata: pixel [7:0]. tlast: row_end.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [epi_ec_pkg::PIX_W-1:0]           s_axis_tdata,
    input  logic                                   s_axis_tlast,
    // Result stream. tdata: confidence [19:0], column [29:20], zero pad [31:30].
    // tuser: edge_res. tlast: last_of_row.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [epi_ec_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast,
    // Register write channel.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [epi_ec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [epi_ec_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // The ring keeps the last 2*MAX_HALF+1 pixels; a slot is the column modulo its depth,
    // tracked incrementally so that no modulo is ever formed.
    localparam int RING_DEPTH = 2 * MAX_HALF + 1;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int CW         = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int EW         = $clog2(MAX_COLUMNS + 2 * MAX_HALF + 1) + 1;
    localparam int ACC_W      = $clog2(RING_DEPTH * epi_ec_pkg::SQ_MAX + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_EMIT
    } state_t;

    state_t                            state_reg, state_next;
    logic [epi_ec_pkg::CONF_W-1:0]     threshold_reg, threshold_next;
    logic [epi_ec_pkg::HALF_W-1:0]     half_window_reg, half_window_next;
    logic [CW-1:0]                     pixel_count_reg, pixel_count_next;
    logic [SLOT_W-1:0]                 wr_slot_reg, wr_slot_next;
    logic [CW-1:0]                     next_center_reg, next_center_next;
    logic [SLOT_W-1:0]                 center_slot_reg, center_slot_next;
    logic [CW-1:0]                     p_reg, p_next;
    logic                              at_end_reg, at_end_next;
    logic [EW-1:0]                     h_reg, h_next;
    logic [CNT_W-1:0]                  n_reg, n_next;
    logic [SLOT_W-1:0]                 rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0]                  terms_reg, terms_next;
    logic                              cen_vld_reg, cen_vld_next;
    logic                              rd_vld_reg, rd_vld_next;
    logic                              prod_vld_reg, prod_vld_next;
    logic [epi_ec_pkg::PIX_W-1:0]      center_reg, center_next;
    logic [epi_ec_pkg::SQ_W-1:0]       prod_reg, prod_next;
    logic [ACC_W-1:0]                  acc_reg, acc_next;
    logic                              m_valid_reg, m_valid_next;
    logic [epi_ec_pkg::CONF_W-1:0]     m_conf_reg, m_conf_next;
    logic [epi_ec_pkg::COL_W-1:0]      m_col_reg, m_col_next;
    logic                              m_edge_reg, m_edge_next;
    logic                              m_last_reg, m_last_next;

    // Pixel ring: one write port, one registered read port.
    logic [epi_ec_pkg::PIX_W-1:0]      ring_mem [RING_DEPTH];
    logic [epi_ec_pkg::PIX_W-1:0]      rd_data_reg;
    logic [SLOT_W-1:0]                 rd_addr;
    logic                              ring_we;

    // Window bounds for the pending centre, worked out in the check state.
    logic [EW-1:0]                     c_ext, p_ext, s_a, e_a, s_b, e_b, shift, offset;
    logic                              left, overshoot, go;
    logic [SLOT_W:0]                   cs_ext, off_s;
    logic [SLOT_W-1:0]                 start_slot;
    logic [epi_ec_pkg::PIX_W-1:0]      abs_diff;
    logic                              issue, in_xfer, out_load;
    logic [epi_ec_pkg::CONF_W-1:0]     conf_val;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign ring_we       = in_xfer;
    assign rd_addr       = (state_reg == ST_RUN) ? rd_slot_reg : center_slot_reg;

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wr_slot_reg] <= s_axis_tdata;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    // Window placement: shifted right at the left edge, shifted left (and clamped to the
    // row start) at the row end, and trimmed to the last pixel received otherwise.
    always_comb
    begin
        c_ext     = EW'(next_center_reg);
        p_ext     = EW'(p_reg);
        left      = c_ext < h_reg;
        s_a       = left ? '0 : c_ext - h_reg;
        e_a       = left ? (h_reg << 1) : c_ext + h_reg;
        overshoot = e_a > p_ext;
        shift     = e_a - p_ext;
        if (at_end_reg && overshoot)
        begin
            s_b = (s_a >= shift) ? s_a - shift : '0;
            e_b = p_ext;
        end
        else
        begin
            s_b = s_a;
            e_b = overshoot ? p_ext : e_a;
        end
        go     = (c_ext <= p_ext) && (n_reg < CNT_W'(RING_DEPTH))
                 && (at_end_reg || !overshoot);
        offset = c_ext - s_b;
        cs_ext = {1'b0, center_slot_reg};
        off_s  = (SLOT_W + 1)'(offset);
        if (cs_ext >= off_s)
        begin
            start_slot = SLOT_W'(cs_ext - off_s);
        end
        else
        begin
            start_slot = SLOT_W'(cs_ext + (SLOT_W + 1)'(RING_DEPTH) - off_s);
        end
    end

    assign abs_diff = (rd_data_reg >= center_reg) ? rd_data_reg - center_reg
                                                  : center_reg - rd_data_reg;
    assign issue    = (terms_reg != '0);
    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_axis_tready);
    assign conf_val = epi_ec_pkg::CONF_W'(acc_reg);

    always_comb
    begin
        state_next       = state_reg;
        threshold_next   = threshold_reg;
        half_window_next = half_window_reg;
        pixel_count_next = pixel_count_reg;
        wr_slot_next     = wr_slot_reg;
        next_center_next = next_center_reg;
        center_slot_next = center_slot_reg;
        p_next           = p_reg;
        at_end_next      = at_end_reg;
        h_next           = h_reg;
        n_next           = n_reg;
        rd_slot_next     = rd_slot_reg;
        terms_next       = terms_reg;
        cen_vld_next     = 1'b0;
        rd_vld_next      = 1'b0;
        prod_vld_next    = 1'b0;
        center_next      = center_reg;
        prod_next        = prod_reg;
        acc_next         = acc_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        m_conf_next      = m_conf_reg;
        m_col_next       = m_col_reg;
        m_edge_next      = m_edge_reg;
        m_last_next      = m_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                epi_ec_pkg::CFG_THRESHOLD:
                begin
                    threshold_next = cfg_data[epi_ec_pkg::CONF_W-1:0];
                end
                epi_ec_pkg::CFG_HALF_WINDOW:
                begin
                    half_window_next = cfg_data[epi_ec_pkg::HALF_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    p_next      = pixel_count_reg;
                    at_end_next = s_axis_tlast
                                  || (pixel_count_reg >= CW'(MAX_COLUMNS - 1));
                    h_next      = (int'(half_window_reg) > MAX_HALF)
                                  ? EW'(MAX_HALF) : EW'(half_window_reg);
                    n_next      = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (go)
                begin
                    // The centre pixel is being read this cycle.
                    rd_slot_next = start_slot;
                    terms_next   = CNT_W'(e_b - s_b + 1'b1);
                    cen_vld_next = 1'b1;
                    acc_next     = '0;
                    state_next   = ST_RUN;
                end
                else
                begin
                    if (at_end_reg)
                    begin
                        pixel_count_next = '0;
                        wr_slot_next     = '0;
                        next_center_next = '0;
                        center_slot_next = '0;
                    end
                    else
                    begin
                        pixel_count_next = pixel_count_reg + 1'b1;
                        wr_slot_next     = slot_inc(wr_slot_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                // Read, square, accumulate: one term enters each cycle.
                if (cen_vld_reg)
                begin
                    center_next = rd_data_reg;
                end
                if (issue)
                begin
                    terms_next   = terms_reg - 1'b1;
                    rd_slot_next = slot_inc(rd_slot_reg);
                end
                rd_vld_next = issue;
                if (rd_vld_reg)
                begin
                    prod_next = {{epi_ec_pkg::PIX_W{1'b0}}, abs_diff}
                                * {{epi_ec_pkg::PIX_W{1'b0}}, abs_diff};
                end
                prod_vld_next = rd_vld_reg;
                if (prod_vld_reg)
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                if (!issue && !cen_vld_reg && !rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    m_valid_next     = 1'b1;
                    m_conf_next      = conf_val;
                    m_edge_next      = (conf_val >= threshold_reg);
                    m_col_next       = epi_ec_pkg::COL_W'(next_center_reg);
                    m_last_next      = at_end_reg && (next_center_reg == p_reg);
                    next_center_next = next_center_reg + 1'b1;
                    center_slot_next = slot_inc(center_slot_reg);
                    n_next           = n_reg + 1'b1;
                    state_next       = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            threshold_reg   <= epi_ec_pkg::THRESHOLD_RST;
            half_window_reg <= epi_ec_pkg::HALF_WINDOW_RST;
            pixel_count_reg <= '0;
            wr_slot_reg     <= '0;
            next_center_reg <= '0;
            center_slot_reg <= '0;
            p_reg           <= '0;
            at_end_reg      <= 1'b0;
            h_reg           <= '0;
            n_reg           <= '0;
            rd_slot_reg     <= '0;
            terms_reg       <= '0;
            cen_vld_reg     <= 1'b0;
            rd_vld_reg      <= 1'b0;
            prod_vld_reg    <= 1'b0;
            center_reg      <= '0;
            prod_reg        <= '0;
            acc_reg         <= '0;
            m_valid_reg     <= 1'b0;
            m_conf_reg      <= '0;
            m_col_reg       <= '0;
            m_edge_reg      <= 1'b0;
            m_last_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            threshold_reg   <= threshold_next;
            half_window_reg <= half_window_next;
            pixel_count_reg <= pixel_count_next;
            wr_slot_reg     <= wr_slot_next;
            next_center_reg <= next_center_next;
            center_slot_reg <= center_slot_next;
            p_reg           <= p_next;
            at_end_reg      <= at_end_next;
            h_reg           <= h_next;
            n_reg           <= n_next;
            rd_slot_reg     <= rd_slot_next;
            terms_reg       <= terms_next;
            cen_vld_reg     <= cen_vld_next;
            rd_vld_reg      <= rd_vld_next;
            prod_vld_reg    <= prod_vld_next;
            center_reg      <= center_next;
            prod_reg        <= prod_next;
            acc_reg         <= acc_next;
            m_valid_reg     <= m_valid_next;
            m_conf_reg      <= m_conf_next;
            m_col_reg       <= m_col_next;
            m_edge_reg      <= m_edge_next;
            m_last_reg      <= m_last_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(epi_ec_pkg::OUT_TDATA_W - epi_ec_pkg::CONF_W
                             - epi_ec_pkg::COL_W){1'b0}}, m_col_reg, m_conf_reg};
    assign m_axis_tuser  = m_edge_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== hw/rtl/epi_ec_checker.sv =====
// Port-level checks for the EPI edge-confidence block, bound to its top level.
// Depends on epi_ec_pkg for the result word layout.
module epi_ec_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [epi_ec_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result stays offered.
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its word.
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Once a pixel is taken the block is busy with it for at least the next cycle.
    a_busy_after_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("pixel taken while the previous one is in work");

    // The pad bits above the column field are always zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[epi_ec_pkg::OUT_TDATA_W-1:
                           epi_ec_pkg::CONF_W+epi_ec_pkg::COL_W] == '0))
        else $error("result pad bits not zero");

endmodule

bind epi_edge_confidence epi_ec_checker u_epi_ec_checker (.*);
